@@ hw/rtl/skmct_pkg.sv @@
// ----------------------------------------------------------------------------
// skmct_pkg
// Shared types and constants for the skin mask color tint block: fixed-point
// YCrCb coefficients, register indexes and reset values, configuration struct.
// ----------------------------------------------------------------------------
package skmct_pkg;

  // 14-bit fixed-point conversion coefficients
  localparam int SHIFT_BITS = 14;
  localparam int K_RY       = 4899;
  localparam int K_GY       = 9617;
  localparam int K_BY       = 1868;
  localparam int K_CR       = 11682;
  localparam int K_CB       = 9241;
  localparam int ROUND_HALF = 1 << (SHIFT_BITS - 1);
  localparam int CHROMA_OFS = (128 << SHIFT_BITS) + ROUND_HALF;

  // Register indexes
  localparam logic [2:0] REG_CR_LOW     = 3'd0;
  localparam logic [2:0] REG_CR_HIGH    = 3'd1;
  localparam logic [2:0] REG_CB_LOW     = 3'd2;
  localparam logic [2:0] REG_CB_HIGH    = 3'd3;
  localparam logic [2:0] REG_TINT_BLUE  = 3'd4;
  localparam logic [2:0] REG_TINT_GREEN = 3'd5;
  localparam logic [2:0] REG_TINT_RED   = 3'd6;

  // Register reset values
  localparam logic [7:0] RST_CR_LOW     = 8'd133;
  localparam logic [7:0] RST_CR_HIGH    = 8'd173;
  localparam logic [7:0] RST_CB_LOW     = 8'd77;
  localparam logic [7:0] RST_CB_HIGH    = 8'd127;
  localparam logic [7:0] RST_TINT_BLUE  = 8'd0;
  localparam logic [7:0] RST_TINT_GREEN = 8'd255;
  localparam logic [7:0] RST_TINT_RED   = 8'd0;

  typedef struct packed {
    logic [7:0] cr_low;
    logic [7:0] cr_high;
    logic [7:0] cb_low;
    logic [7:0] cb_high;
    logic [7:0] tint_blue;
    logic [7:0] tint_green;
    logic [7:0] tint_red;
  } skmct_cfg_t;

endpackage

@@ hw/rtl/skmct_pixel.sv @@
// ----------------------------------------------------------------------------
// skmct_pixel
// Per-pixel datapath: BGR to luma and chroma, skin window test, saturating
// tint of skin pixels. Purely combinational; sits between two registers.
// ----------------------------------------------------------------------------
module skmct_pixel (
  input  skmct_pkg::skmct_cfg_t cfg,
  input  logic [7:0]            in_blue,
  input  logic [7:0]            in_green,
  input  logic [7:0]            in_red,
  output logic [7:0]            out_blue,
  output logic [7:0]            out_green,
  output logic [7:0]            out_red,
  output logic                  skin_flag
);
  import skmct_pkg::*;

  logic        [21:0] y_sum;
  logic        [7:0]  luma;
  logic signed [8:0]  diff_r;
  logic signed [8:0]  diff_b;
  logic        [7:0]  cr;
  logic        [7:0]  cb;
  logic        [8:0]  sum_b;
  logic        [8:0]  sum_g;
  logic        [8:0]  sum_r;

  // Floor shift of diff*k plus bias, then clamp to 0..255
  function automatic logic [7:0] chroma(input logic signed [8:0] diff,
                                        input logic [13:0] k);
    logic signed [23:0] prod;
    logic signed [23:0] sum;
    logic        [7:0]  res;
    prod = 24'(diff) * $signed({10'd0, k});
    sum  = prod + $signed(24'(CHROMA_OFS));
    if (sum[23]) begin
      res = 8'd0;
    end else if (sum[22]) begin
      res = 8'd255;
    end else begin
      res = sum[21:14];
    end
    return res;
  endfunction

  always_comb begin
    y_sum = 22'(K_RY) * 22'(in_red) + 22'(K_GY) * 22'(in_green)
          + 22'(K_BY) * 22'(in_blue) + 22'(ROUND_HALF);
  end

  assign luma   = y_sum[21:14];
  assign diff_r = $signed({1'b0, in_red})  - $signed({1'b0, luma});
  assign diff_b = $signed({1'b0, in_blue}) - $signed({1'b0, luma});
  assign cr     = chroma(diff_r, 14'(K_CR));
  assign cb     = chroma(diff_b, 14'(K_CB));

  assign skin_flag = (cr >= cfg.cr_low) && (cr <= cfg.cr_high) &&
                     (cb >= cfg.cb_low) && (cb <= cfg.cb_high);

  assign sum_b = {1'b0, in_blue}  + {1'b0, cfg.tint_blue};
  assign sum_g = {1'b0, in_green} + {1'b0, cfg.tint_green};
  assign sum_r = {1'b0, in_red}   + {1'b0, cfg.tint_red};

  always_comb begin
    out_blue  = in_blue;
    out_green = in_green;
    out_red   = in_red;
    if (skin_flag) begin
      out_blue  = sum_b[8] ? 8'd255 : sum_b[7:0];
      out_green = sum_g[8] ? 8'd255 : sum_g[7:0];
      out_red   = sum_r[8] ? 8'd255 : sum_r[7:0];
    end
  end

endmodule

@@ hw/rtl/skin_mask_color_tint_core.sv @@
// ----------------------------------------------------------------------------
// skin_mask_color_tint_core
// Skin detection in YCrCb space with a saturating per-channel tint.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready carries one BGR pixel per item
//   (in_blue, in_green, in_red). Output channel out_valid/out_ready carries
//   the tinted pixel and skin_flag, exactly one result item per input item,
//   in order.
//   Path: an item accepted enters the input register; its result is loaded
//   into the output register once that register is empty or draining, and
//   is presented from the output register.
//   Throughput: one item per cycle while out_ready stays high. The input and
//   output registers form a two-entry pipeline; the input side keeps taking
//   items while a result waits, as long as the output register can drain.
//   When the receiver stalls, the result holds in the output register, the
//   next item holds in the input register, and in_ready drops once both are
//   full.
//   Configuration: cfg_wr_en writes cfg_data[7:0] into register cfg_index
//   (0 cr_low, 1 cr_high, 2 cb_low, 3 cb_high, 4..6 tint blue/green/red);
//   index 7 is ignored. Write only while the block is empty.
//   Reset (rst, synchronous): empties both registers and loads the default
//   skin window and tint.
// ----------------------------------------------------------------------------
module skin_mask_color_tint_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_blue,
  input  logic [7:0] in_green,
  input  logic [7:0] in_red,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_blue,
  output logic [7:0] out_green,
  output logic [7:0] out_red,
  output logic       skin_flag
);
  import skmct_pkg::*;

  skmct_cfg_t cfg;

  // Input register
  logic       s0_valid;
  logic [7:0] s0_blue;
  logic [7:0] s0_green;
  logic [7:0] s0_red;

  // Datapath results
  logic [7:0] px_blue;
  logic [7:0] px_green;
  logic [7:0] px_red;
  logic       px_skin;

  logic out_take;   // output register can load this cycle
  logic s0_move;    // input register item advances to output

  // Configuration registers: decode the index, ignore unused codes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cr_low     <= RST_CR_LOW;
      cfg.cr_high    <= RST_CR_HIGH;
      cfg.cb_low     <= RST_CB_LOW;
      cfg.cb_high    <= RST_CB_HIGH;
      cfg.tint_blue  <= RST_TINT_BLUE;
      cfg.tint_green <= RST_TINT_GREEN;
      cfg.tint_red   <= RST_TINT_RED;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CR_LOW:     cfg.cr_low     <= cfg_data;
        REG_CR_HIGH:    cfg.cr_high    <= cfg_data;
        REG_CB_LOW:     cfg.cb_low     <= cfg_data;
        REG_CB_HIGH:    cfg.cb_high    <= cfg_data;
        REG_TINT_BLUE:  cfg.tint_blue  <= cfg_data;
        REG_TINT_GREEN: cfg.tint_green <= cfg_data;
        REG_TINT_RED:   cfg.tint_red   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Handshake: output drains or is empty -> input register may advance
  assign out_take = !out_valid || out_ready;
  assign s0_move  = s0_valid && out_take;
  assign in_ready = !s0_valid || out_take;

  // Input register: load on accept, drop when the item advances
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s0_valid <= 1'b1;
    end else if (s0_move) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s0_blue  <= in_blue;
      s0_green <= in_green;
      s0_red   <= in_red;
    end
  end

  skmct_pixel u_pixel (
    .cfg       (cfg),
    .in_blue   (s0_blue),
    .in_green  (s0_green),
    .in_red    (s0_red),
    .out_blue  (px_blue),
    .out_green (px_green),
    .out_red   (px_red),
    .skin_flag (px_skin)
  );

  // Output register: advance a new result, hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_take) begin
      out_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s0_move) begin
      out_blue  <= px_blue;
      out_green <= px_green;
      out_red   <= px_red;
      skin_flag <= px_skin;
    end
  end

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !s0_valid))
    else $error("pipeline not empty after reset");

  a_advance_lands: assert property (@(posedge clk) disable iff (rst)
    s0_move |=> out_valid)
    else $error("advanced item did not reach the output register");

  a_passthrough: assert property (@(posedge clk) disable iff (rst)
    s0_move |=> (skin_flag || (out_blue == $past(s0_blue) &&
                 out_green == $past(s0_green) && out_red == $past(s0_red))))
    else $error("non-skin pixel was modified");

  a_tint_grows: assert property (@(posedge clk) disable iff (rst)
    s0_move |=> (out_blue >= $past(s0_blue) && out_green >= $past(s0_green) &&
                 out_red >= $past(s0_red)))
    else $error("tint decreased a channel");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");
`endif

endmodule
